// ===== hw/rtl/incl_fd_pkg.sv =====
// Shared constants and digit-pair arithmetic for the inclinometer frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package incl_fd_pkg;

  localparam int FRAME_BYTES = 14;
  localparam int POS_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int BYTE_W      = 8;
  localparam int ANGLE_W     = 16;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  localparam logic [POS_W-1:0] POS_HUNT    = 4'd0;
  localparam logic [POS_W-1:0] POS_HEADER2 = 4'd1;
  localparam logic [POS_W-1:0] POS_BODY    = 4'd2;
  localparam logic [POS_W-1:0] POS_SIGN_X  = 4'd4;
  localparam logic [POS_W-1:0] POS_WHOLE_X = 4'd5;
  localparam logic [POS_W-1:0] POS_FRAC_X  = 4'd6;
  localparam logic [POS_W-1:0] POS_SIGN_Y  = 4'd7;
  localparam logic [POS_W-1:0] POS_WHOLE_Y = 4'd8;
  localparam logic [POS_W-1:0] POS_FRAC_Y  = 4'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEGATIVE_MARKER = 2'd2;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST    = 8'h77;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST   = 8'h0D;
  localparam logic [BYTE_W-1:0] NEGATIVE_MARKER_RST = 8'h10;

  function automatic logic [BYTE_W-1:0] pair_value(input logic [BYTE_W-1:0] b);
    pair_value = BYTE_W'(b[7:4]) * 8'd10 + BYTE_W'(b[3:0]);
  endfunction

  function automatic logic [ANGLE_W-1:0] angle_bits(input logic neg,
                                                     input logic [BYTE_W-1:0] whole,
                                                     input logic [BYTE_W-1:0] frac);
    logic [ANGLE_W-1:0] mag;
    mag = ANGLE_W'(pair_value(whole)) * 16'd100 + ANGLE_W'(pair_value(frac));
    angle_bits = neg ? (16'd0 - mag) : mag;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/inclinometer_frame_decoder_unit.sv =====
// Inclinometer frame decoder: header hunt, frame capture and angle output register.
// The result is registered and appears on the outputs in the cycle after the last frame byte is taken.
// Throughput: one byte per cycle; only a frame-ending byte waits on a held result.
// Reset: hunting for the header, captured fields zero, configuration registers at their defaults.
`timescale 1ns / 1ps
`default_nettype none

module inclinometer_frame_decoder_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_wr_en_i,
  input  wire logic [incl_fd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [incl_fd_pkg::BYTE_W-1:0]        cfg_data_i,
  input  wire logic                                  in_valid_i,
  output      logic                                  in_stall_o,
  input  wire logic [incl_fd_pkg::BYTE_W-1:0]        rx_byte_i,
  output      logic                                  out_valid_o,
  input  wire logic                                  out_stall_i,
  output      logic signed [incl_fd_pkg::ANGLE_W-1:0] angle_x_hundredths_o,
  output      logic signed [incl_fd_pkg::ANGLE_W-1:0] angle_y_hundredths_o
);

  logic [incl_fd_pkg::BYTE_W-1:0]  header_first_q, header_second_q, negative_marker_q;
  logic [incl_fd_pkg::POS_W-1:0]   pos_q, pos_d;
  logic                            neg_x_q, neg_y_q;
  logic [incl_fd_pkg::BYTE_W-1:0]  whole_x_q, frac_x_q, whole_y_q, frac_y_q;
  logic                            out_valid_q, out_valid_d;
  logic [incl_fd_pkg::ANGLE_W-1:0] angle_x_q, angle_y_q;
  logic [incl_fd_pkg::BYTE_W-1:0]  frac_y_sel;
  logic                            accept, is_last, emit, is_neg;

  assign is_last    = (pos_q >= incl_fd_pkg::LAST_POS);
  assign in_stall_o = is_last & out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign emit       = accept & is_last;
  assign is_neg     = (rx_byte_i == negative_marker_q);
  assign frac_y_sel = (pos_q == incl_fd_pkg::POS_FRAC_Y) ? rx_byte_i : frac_y_q;

  always_comb begin
    pos_d = pos_q;
    case (pos_q)
      incl_fd_pkg::POS_HUNT: begin
        pos_d = (rx_byte_i == header_first_q) ? incl_fd_pkg::POS_HEADER2
                                              : incl_fd_pkg::POS_HUNT;
      end
      incl_fd_pkg::POS_HEADER2: begin
        if (rx_byte_i == header_second_q) begin
          pos_d = incl_fd_pkg::POS_BODY;
        end else if (rx_byte_i == header_first_q) begin
          pos_d = incl_fd_pkg::POS_HEADER2;
        end else begin
          pos_d = incl_fd_pkg::POS_HUNT;
        end
      end
      default: begin
        pos_d = is_last ? incl_fd_pkg::POS_HUNT : pos_q + 4'd1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_first_q    <= incl_fd_pkg::HEADER_FIRST_RST;
      header_second_q   <= incl_fd_pkg::HEADER_SECOND_RST;
      negative_marker_q <= incl_fd_pkg::NEGATIVE_MARKER_RST;
    end else if (cfg_wr_en_i) begin
      case (cfg_index_i)
        incl_fd_pkg::CFG_HEADER_FIRST:    header_first_q    <= cfg_data_i;
        incl_fd_pkg::CFG_HEADER_SECOND:   header_second_q   <= cfg_data_i;
        incl_fd_pkg::CFG_NEGATIVE_MARKER: negative_marker_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= incl_fd_pkg::POS_HUNT;
      neg_x_q     <= 1'b0;
      neg_y_q     <= 1'b0;
      whole_x_q   <= '0;
      frac_x_q    <= '0;
      whole_y_q   <= '0;
      frac_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        pos_q <= pos_d;
        case (pos_q)
          incl_fd_pkg::POS_SIGN_X:  neg_x_q   <= is_neg;
          incl_fd_pkg::POS_WHOLE_X: whole_x_q <= rx_byte_i;
          incl_fd_pkg::POS_FRAC_X:  frac_x_q  <= rx_byte_i;
          incl_fd_pkg::POS_SIGN_Y:  neg_y_q   <= is_neg;
          incl_fd_pkg::POS_WHOLE_Y: whole_y_q <= rx_byte_i;
          incl_fd_pkg::POS_FRAC_Y:  frac_y_q  <= rx_byte_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      angle_x_q <= incl_fd_pkg::angle_bits(neg_x_q, whole_x_q, frac_x_q);
      angle_y_q <= incl_fd_pkg::angle_bits(neg_y_q, whole_y_q, frac_y_sel);
    end
  end

  assign out_valid_o          = out_valid_q;
  assign angle_x_hundredths_o = angle_x_q;
  assign angle_y_hundredths_o = angle_y_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the inclinometer frame decoder: byte stimulus, angle scoreboard.
`timescale 1ns / 1ps

module testbench;
  import incl_fd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 125;

  typedef struct {
    logic signed [ANGLE_W-1:0] x;
    logic signed [ANGLE_W-1:0] y;
  } angle_pair_t;

  class angle_scoreboard;
    logic [BYTE_W-1:0] hdr_first;
    logic [BYTE_W-1:0] hdr_second;
    logic [BYTE_W-1:0] neg_mark;
    logic [POS_W-1:0]  pos;
    logic              neg_x;
    logic              neg_y;
    logic [BYTE_W-1:0] whole_x;
    logic [BYTE_W-1:0] frac_x;
    logic [BYTE_W-1:0] whole_y;
    logic [BYTE_W-1:0] frac_y;
    angle_pair_t       pending_angles[$];
    int                errors;

    function new();
      hdr_first  = HEADER_FIRST_RST;
      hdr_second = HEADER_SECOND_RST;
      neg_mark   = NEGATIVE_MARKER_RST;
      pos        = POS_HUNT;
      neg_x      = 1'b0;
      neg_y      = 1'b0;
      whole_x    = '0;
      frac_x     = '0;
      whole_y    = '0;
      frac_y     = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] v);
      case (idx)
        CFG_HEADER_FIRST:    hdr_first  = v;
        CFG_HEADER_SECOND:   hdr_second = v;
        CFG_NEGATIVE_MARKER: neg_mark   = v;
        default: ;
      endcase
    endfunction

    function logic signed [ANGLE_W-1:0] signed_angle(logic neg, logic [BYTE_W-1:0] whole,
                                                      logic [BYTE_W-1:0] frac);
      int mag;
      mag = (whole[7:4] * 10 + whole[3:0]) * 100 + frac[7:4] * 10 + frac[3:0];
      return ANGLE_W'(neg ? -mag : mag);
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      angle_pair_t res;
      if (pos == POS_HUNT) begin
        pos = (b == hdr_first) ? POS_HEADER2 : POS_HUNT;
      end else if (pos == POS_HEADER2) begin
        if (b == hdr_second) pos = POS_BODY;
        else pos = (b == hdr_first) ? POS_HEADER2 : POS_HUNT;
      end else begin
        case (pos)
          POS_SIGN_X:  neg_x   = (b == neg_mark);
          POS_WHOLE_X: whole_x = b;
          POS_FRAC_X:  frac_x  = b;
          POS_SIGN_Y:  neg_y   = (b == neg_mark);
          POS_WHOLE_Y: whole_y = b;
          POS_FRAC_Y:  frac_y  = b;
          default: ;
        endcase
        if (pos >= LAST_POS) begin
          res.x = signed_angle(neg_x, whole_x, frac_x);
          res.y = signed_angle(neg_y, whole_y, frac_y);
          pending_angles.push_back(res);
          pos = POS_HUNT;
        end else begin
          pos = pos + 1'b1;
        end
      end
    endfunction

    function void check_angles(logic signed [ANGLE_W-1:0] x, logic signed [ANGLE_W-1:0] y);
      angle_pair_t exp_pair;
      if (pending_angles.size() == 0) begin
        $display("%0t: angle beat with no frame pending: x=%0d y=%0d", $time, x, y);
        errors++;
        return;
      end
      exp_pair = pending_angles.pop_front();
      if (x !== exp_pair.x) begin
        $display("%0t: angle_x mismatch: expected %0d actual %0d", $time, exp_pair.x, x);
        errors++;
      end
      if (y !== exp_pair.y) begin
        $display("%0t: angle_y mismatch: expected %0d actual %0d", $time, exp_pair.y, y);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_wr_en_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [BYTE_W-1:0]          cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [BYTE_W-1:0]          rx_byte_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [ANGLE_W-1:0]  angle_x_hundredths_o;
  logic signed [ANGLE_W-1:0]  angle_y_hundredths_o;

  angle_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  rx_stall_pct = 0;
  bit  hold_rx_go = 1'b0;
  int  cycle_count = 0;

  inclinometer_frame_decoder_unit i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_wr_en_i          (cfg_wr_en_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .rx_byte_i            (rx_byte_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .angle_x_hundredths_o (angle_x_hundredths_o),
    .angle_y_hundredths_o (angle_y_hundredths_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.take_byte(rx_byte_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_angles(angle_x_hundredths_o, angle_y_hundredths_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d frames still pending", $time, sb.pending_angles.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_rx_go) begin
        hold_rx_go = 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_frame();
    logic [BYTE_W-1:0] b;
    int i;
    for (i = 0; i < FRAME_BYTES; i++) begin
      b = BYTE_W'($urandom_range(255));
      if (i == POS_HUNT) b = sb.hdr_first;
      else if (i == POS_HEADER2) b = sb.hdr_second;
      else if (i == POS_SIGN_X || i == POS_SIGN_Y) begin
        if ($urandom_range(1)) b = sb.neg_mark;
      end else if (i >= POS_WHOLE_X && i <= POS_FRAC_Y && $urandom_range(1)) begin
        b = {4'($urandom_range(9)), 4'($urandom_range(9))};
      end
      send_byte(b);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_angles.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_config(input logic [BYTE_W-1:0] hf, input logic [BYTE_W-1:0] hs,
                              input logic [BYTE_W-1:0] nm);
    write_reg(CFG_HEADER_FIRST, hf);
    write_reg(CFG_HEADER_SECOND, hs);
    write_reg(CFG_NEGATIVE_MARKER, nm);
    write_reg(CFG_UNUSED, BYTE_W'($urandom_range(255)));
    cfg_wr_en_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    logic [BYTE_W-1:0] seq [19];
    int i;
    seq = '{8'h00, 8'hFF, HEADER_FIRST_RST, 8'h00, HEADER_FIRST_RST, HEADER_FIRST_RST,
            HEADER_SECOND_RST, 8'h00, 8'hFF, NEGATIVE_MARKER_RST, 8'hFF, 8'hFF,
            NEGATIVE_MARKER_RST, 8'h00, 8'h00, 8'h5A, 8'hA5, 8'hFF, 8'h00};
    for (i = 0; i < 19; i++) send_byte(seq[i]);
  endtask

  task automatic run_random(input int items);
    int sent;
    int r;
    int k;
    int j;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_frame();
        sent += FRAME_BYTES;
      end else if (r < 80) begin
        send_byte(sb.hdr_first);
        send_byte(BYTE_W'($urandom_range(255)));
        sent += 2;
      end else if (r < 90) begin
        k = $urandom_range(1, 10);
        send_byte(sb.hdr_first);
        send_byte(sb.hdr_second);
        for (j = 0; j < k; j++) send_byte(BYTE_W'($urandom_range(255)));
        sent += k + 2;
      end else begin
        k = $urandom_range(1, 4);
        for (j = 0; j < k; j++) send_byte(BYTE_W'($urandom_range(255)));
        sent += k;
      end
    end
  endtask

  initial begin
    int f;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    drain();

    apply_config(8'h00, 8'hFF, 8'hFF);
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    run_random(PHASE_ITEMS);
    drain();

    apply_config(8'hFF, 8'h00, 8'h00);
    send_idle_pct = 59;
    rx_stall_pct  = 0;
    run_random(PHASE_ITEMS);
    drain();

    apply_config(8'hAA, 8'hAA, BYTE_W'($urandom_range(255)));
    send_idle_pct = 0;
    rx_stall_pct  = 59;
    run_random(PHASE_ITEMS);
    drain();

    apply_config(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                 BYTE_W'($urandom_range(255)));
    send_idle_pct = 35;
    rx_stall_pct  = 35;
    run_random(PHASE_ITEMS);
    drain();

    apply_config(HEADER_FIRST_RST, HEADER_SECOND_RST, NEGATIVE_MARKER_RST);
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    hold_rx_go = 1'b1;
    for (f = 0; f < 3; f++) send_frame();
    drain();
    send_idle_pct = 35;
    rx_stall_pct  = 35;
    run_random(PHASE_ITEMS);
    drain();

    if (sb.errors == 0 && sb.pending_angles.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== inclinometer_frame_decoder_unit.f =====
hw/rtl/incl_fd_pkg.sv
hw/rtl/inclinometer_frame_decoder_unit.sv
tb/testbench.sv
